// ===== hw/rtl/cmsc_pkg.sv =====
// Package for the conveyor metal-sort controller: mode codes, drive codes
// and the scan word and output latch types shared by all controller files.
// No dependencies.
`default_nettype none

package cmsc_pkg;

   // Mode codes
   localparam logic [3:0] MODE_START   = 4'd0;
   localparam logic [3:0] MODE_STANDBY = 4'd1;
   localparam logic [3:0] MODE_READY   = 4'd2;
   localparam logic [3:0] MODE_TRANSP  = 4'd3;
   localparam logic [3:0] MODE_MCHECK  = 4'd4;
   localparam logic [3:0] MODE_NONMET  = 4'd5;
   localparam logic [3:0] MODE_END     = 4'd6;
   localparam logic [3:0] MODE_METAL   = 4'd7;
   localparam logic [3:0] MODE_SLIDE   = 4'd8;
   localparam logic [3:0] MODE_ERROR   = 4'd9;
   localparam logic [3:0] MODE_REVERSE = 4'd10;
   localparam logic [3:0] MODE_ENTRY   = 4'd11;

   // Belt motor codes
   localparam logic [1:0] DRV_STOP  = 2'd0;
   localparam logic [1:0] DRV_RIGHT = 2'd1;
   localparam logic [1:0] DRV_LEFT  = 2'd2;

   // One scan tick of sensor and operator bits
   typedef struct packed {
      logic start_released;
      logic part_at_entry;
      logic part_at_exit;
      logic part_at_height_gauge;
      logic part_at_metal_probe;
      logic metal_found;
      logic slide_passed;
      logic part_accepted;
      logic blink_phase;
   } scan_type;

   // Latched lamp, drive and junction outputs
   typedef struct packed {
      logic [1:0] drive;
      logic       lamp_green;
      logic       lamp_red;
      logic       lamp_yellow;
      logic       start_led;
      logic       junction_open;
   } lamp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cmsc_next_mode.sv =====
// Mode transition logic of the conveyor metal-sort controller.
// Depends on cmsc_pkg for mode codes and the scan word type.
`default_nettype none

module cmsc_next_mode (
   input  wire logic [3:0]       mode,
   input  wire cmsc_pkg::scan_type scan,
   output logic [3:0]            mode_next
);
   import cmsc_pkg::*;

   // Check the mode's rules in order; a later match wins
   always_comb begin
      mode_next = mode;
      unique case (mode)
         MODE_START: begin
            mode_next = MODE_STANDBY;
         end
         MODE_STANDBY: begin
            if (scan.start_released) mode_next = MODE_READY;
         end
         MODE_READY: begin
            if (scan.start_released) mode_next = MODE_STANDBY;
            if (scan.part_at_entry && !scan.part_at_exit) mode_next = MODE_TRANSP;
            if (scan.part_at_height_gauge || scan.part_at_metal_probe)
               mode_next = MODE_ERROR;
         end
         MODE_TRANSP: begin
            if (scan.part_at_metal_probe) mode_next = MODE_MCHECK;
            if (!scan.part_accepted) mode_next = MODE_REVERSE;
            if (scan.part_at_exit) mode_next = MODE_ERROR;
         end
         MODE_MCHECK: begin
            mode_next = scan.metal_found ? MODE_METAL : MODE_NONMET;
         end
         MODE_NONMET: begin
            if (scan.part_at_exit) mode_next = MODE_END;
            if (scan.part_at_entry || scan.part_at_height_gauge) mode_next = MODE_ERROR;
         end
         MODE_END: begin
            if (scan.start_released) mode_next = MODE_STANDBY;
            if (!scan.part_at_exit) mode_next = MODE_READY;
            if (scan.part_at_metal_probe || scan.part_at_height_gauge)
               mode_next = MODE_ERROR;
         end
         MODE_METAL: begin
            if (scan.slide_passed) mode_next = MODE_SLIDE;
            if (scan.part_at_entry || scan.part_at_height_gauge) mode_next = MODE_ERROR;
         end
         MODE_SLIDE: begin
            if (scan.start_released) mode_next = MODE_STANDBY;
            if (scan.part_at_entry) mode_next = MODE_TRANSP;
            if (scan.part_at_exit || scan.part_at_height_gauge) mode_next = MODE_ERROR;
         end
         MODE_ERROR: begin
            if (scan.start_released) mode_next = MODE_STANDBY;
         end
         MODE_REVERSE: begin
            if (scan.part_at_entry) mode_next = MODE_ENTRY;
            if (scan.part_at_metal_probe || scan.part_at_exit) mode_next = MODE_ERROR;
         end
         MODE_ENTRY: begin
            if (!scan.part_at_entry) mode_next = MODE_READY;
            if (scan.part_at_metal_probe || scan.part_at_height_gauge ||
                scan.part_at_exit)
               mode_next = MODE_ERROR;
         end
         default: begin
            mode_next = MODE_START;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/cmsc_out_decode.sv =====
// Output decode of the conveyor metal-sort controller: lamps, drive and
// junction from the new mode. Depends on cmsc_pkg.
`default_nettype none

module cmsc_out_decode (
   input  wire logic [3:0]         mode,
   input  wire logic               blink_phase,
   input  wire cmsc_pkg::lamp_type lamp_held,
   output cmsc_pkg::lamp_type      lamp_next
);
   import cmsc_pkg::*;

   // Drive what the mode sets; keep every other output as latched
   always_comb begin
      lamp_next = lamp_held;
      unique case (mode)
         MODE_START, MODE_STANDBY: begin
            lamp_next.drive       = DRV_STOP;
            lamp_next.lamp_green  = 1'b0;
            lamp_next.lamp_red    = 1'b0;
            lamp_next.lamp_yellow = 1'b0;
            lamp_next.start_led   = 1'b1;
         end
         MODE_READY: begin
            lamp_next.drive       = DRV_STOP;
            lamp_next.lamp_green  = 1'b1;
            lamp_next.lamp_red    = 1'b0;
            lamp_next.lamp_yellow = 1'b0;
            lamp_next.start_led   = 1'b1;
         end
         MODE_TRANSP: begin
            lamp_next.drive       = DRV_RIGHT;
            lamp_next.lamp_green  = 1'b1;
            lamp_next.lamp_red    = 1'b0;
            lamp_next.lamp_yellow = 1'b0;
            lamp_next.start_led   = 1'b0;
         end
         MODE_MCHECK: begin
            lamp_next.drive       = DRV_STOP;
            lamp_next.lamp_green  = 1'b1;
            lamp_next.lamp_red    = 1'b0;
            lamp_next.lamp_yellow = 1'b0;
         end
         MODE_NONMET: begin
            lamp_next.drive         = DRV_RIGHT;
            lamp_next.lamp_green    = 1'b1;
            lamp_next.lamp_red      = 1'b0;
            lamp_next.lamp_yellow   = 1'b0;
            lamp_next.start_led     = 1'b0;
            lamp_next.junction_open = 1'b1;
         end
         MODE_END: begin
            lamp_next.drive         = DRV_STOP;
            lamp_next.lamp_red      = 1'b0;
            lamp_next.lamp_yellow   = 1'b0;
            lamp_next.junction_open = 1'b0;
            lamp_next.start_led     = 1'b1;
            lamp_next.lamp_green    = blink_phase;
         end
         MODE_METAL: begin
            lamp_next.drive       = DRV_RIGHT;
            lamp_next.lamp_green  = 1'b0;
            lamp_next.lamp_red    = 1'b0;
            lamp_next.lamp_yellow = 1'b1;
         end
         MODE_SLIDE: begin
            lamp_next.drive       = DRV_STOP;
            lamp_next.lamp_green  = 1'b1;
            lamp_next.lamp_red    = 1'b0;
            lamp_next.lamp_yellow = 1'b0;
            lamp_next.start_led   = 1'b1;
         end
         MODE_ERROR: begin
            lamp_next.drive         = DRV_STOP;
            lamp_next.lamp_green    = 1'b0;
            lamp_next.lamp_yellow   = 1'b0;
            lamp_next.start_led     = 1'b1;
            lamp_next.junction_open = 1'b0;
            lamp_next.lamp_red      = blink_phase;
         end
         MODE_REVERSE: begin
            lamp_next.lamp_green  = 1'b0;
            lamp_next.lamp_yellow = 1'b0;
            lamp_next.lamp_red    = blink_phase;
            lamp_next.drive       = DRV_LEFT;
         end
         MODE_ENTRY: begin
            lamp_next.drive       = DRV_STOP;
            lamp_next.lamp_green  = 1'b0;
            lamp_next.lamp_yellow = 1'b0;
         end
         default: begin
            lamp_next = lamp_held;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/conveyor_metal_sort_controller_unit.sv =====
// Top level of the conveyor metal-sort controller: input register, mode and
// output logic, result register. Uses cmsc_pkg, cmsc_next_mode, cmsc_out_decode.
//
//   channel   direction   ports
//   req       in          req_valid, req_ready, nine 1-bit scan fields
//   rsp       out         rsp_valid, rsp_ready, drive, lamps, junction, mode
//
// One scan word per clock while rsp_ready does not stall: a word waits in the
// input register until the result slot is free, then the mode and output latches
// (which form the result register) update as it moves on and rsp_valid rises.
// Synchronous reset puts the controller in start mode with all outputs off. A
// stalled rsp_ready holds the result; the input register still takes one more
// word while the result waits.
`default_nettype none

module conveyor_metal_sort_controller_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_start_released,
   input  wire logic       req_part_at_entry,
   input  wire logic       req_part_at_exit,
   input  wire logic       req_part_at_height_gauge,
   input  wire logic       req_part_at_metal_probe,
   input  wire logic       req_metal_found,
   input  wire logic       req_slide_passed,
   input  wire logic       req_part_accepted,
   input  wire logic       req_blink_phase,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_drive,
   output logic            rsp_lamp_green,
   output logic            rsp_lamp_red,
   output logic            rsp_lamp_yellow,
   output logic            rsp_start_led,
   output logic            rsp_junction_open,
   output logic [3:0]      rsp_mode
);
   import cmsc_pkg::*;

   logic       in_valid_ff;
   scan_type   scan_ff;
   scan_type   scan_in;
   logic       rsp_valid_ff;
   logic [3:0] mode_ff;
   logic [3:0] mode_in;
   lamp_type   lamp_ff;
   lamp_type   lamp_in;
   logic       out_free;
   logic       advance;

   // Handshake: move a word on when the result slot is free
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   assign scan_in = '{
      start_released:       req_start_released,
      part_at_entry:        req_part_at_entry,
      part_at_exit:         req_part_at_exit,
      part_at_height_gauge: req_part_at_height_gauge,
      part_at_metal_probe:  req_part_at_metal_probe,
      metal_found:          req_metal_found,
      slide_passed:         req_slide_passed,
      part_accepted:        req_part_accepted,
      blink_phase:          req_blink_phase
   };

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         scan_ff <= scan_in;
      end
   end

   cmsc_next_mode u_next_mode (
      .mode      (mode_ff),
      .scan      (scan_ff),
      .mode_next (mode_in)
   );

   cmsc_out_decode u_out_decode (
      .mode        (mode_in),
      .blink_phase (scan_ff.blink_phase),
      .lamp_held   (lamp_ff),
      .lamp_next   (lamp_in)
   );

   // Mode and output latches double as the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_START;
         lamp_ff      <= '{drive: DRV_STOP, default: 1'b0};
      end else begin
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            mode_ff <= mode_in;
            lamp_ff <= lamp_in;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive         = lamp_ff.drive;
   assign rsp_lamp_green    = lamp_ff.lamp_green;
   assign rsp_lamp_red      = lamp_ff.lamp_red;
   assign rsp_lamp_yellow   = lamp_ff.lamp_yellow;
   assign rsp_start_led     = lamp_ff.start_led;
   assign rsp_junction_open = lamp_ff.junction_open;
   assign rsp_mode          = mode_ff;

endmodule

`default_nettype wire
